// ===== src/vibration_event_detector_assert.svh =====
// Assertion macros used by the vibration event detector top level.
`ifndef VIBRATION_EVENT_DETECTOR_ASSERT_SVH
`define VIBRATION_EVENT_DETECTOR_ASSERT_SVH

// same-cycle implication under active-low reset
`define VED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication under active-low reset
`define VED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/ved_pkg.sv =====
// Types and constants of the vibration event detector.
package ved_pkg;

    localparam int TIME_W      = 32;
    localparam int MAG_OUT_W   = 20;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int LEVEL_W     = 19;
    localparam int DELTA_W     = 20;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TUSER_W = 6;
    localparam int OUT_TDATA_W = ((TIME_W + MAG_OUT_W + 7) / 8) * 8;

    // input tuser bits
    localparam int U_MOTION = 0;
    localparam int U_ABORT  = 1;
    localparam int U_BUSY   = 2;

    // output tuser bits
    localparam int U_LOG    = 0;
    localparam int U_START  = 1;
    localparam int U_FIN    = 2;
    localparam int U_REASON = 3;
    localparam int U_SETTLE = 5;

    localparam logic [1:0] REASON_SETTLED = 2'd0;
    localparam logic [1:0] REASON_TIMEOUT = 2'd1;
    localparam logic [1:0] REASON_REJECT  = 2'd2;
    localparam logic [1:0] REASON_ABORT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SDELTA    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STIME     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EVENT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENT = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT    = 8'd5;

    localparam logic [LEVEL_W-1:0] RST_TRIGGER   = 19'd12800;
    localparam logic [DELTA_W-1:0] RST_SDELTA    = 20'd2560;
    localparam logic [TIME_W-1:0]  RST_STIME     = 32'd3000;
    localparam logic [TIME_W-1:0]  RST_MIN_EVENT = 32'd3000;
    localparam logic [TIME_W-1:0]  RST_MAX_EVENT = 32'd900000;
    localparam logic [LEVEL_W-1:0] RST_REJECT    = 19'd486400;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAG,
        S_DECIDE
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SQ,
        M_ROOT
    } t_mag_state;

endpackage

// ===== src/vibration_event_detector.sv =====
// Vibration event detector top level: sample intake, event sequencer, result register.
//
// Input stream (s): one item per accelerometer sample, three signed axes and a
// millisecond timestamp in tdata, the motion, abort and busy flags in tuser.
// Output stream (m): exactly one item per input item, in order, giving the
// magnitude, logging and event start/finish flags with the end reason.
// Config channel: a write of index and data, always ready; write it only
// while no item is in flight.
// Flow: a new item is taken once the previous one has reached the output
// register. The magnitude unit sets the pace: one shared squarer over the three
// axes, then a square root that resolves one result bit per cycle.
// Reset: synchronous, active low; clears event state, restores register
// defaults and empties the output register.
// Stall: the finished item waits in the output register; the next item is
// accepted and processed meanwhile and holds in its decision step until the
// output register frees.
`include "vibration_event_detector_assert.svh"

module vibration_event_detector #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_s_tvalid,
    output logic                                                   o_s_tready,
    // accel_x, accel_y, accel_z, time_ms, zero pad
    input  logic [((3*SAMPLE_BITS+ved_pkg::TIME_W+7)/8)*8-1:0]     i_s_tdata,
    // hw_motion, abort_req, store_busy
    input  logic [ved_pkg::IN_TUSER_W-1:0]                         i_s_tuser,
    output logic                                                   o_m_tvalid,
    input  logic                                                   i_m_tready,
    // rel_time_ms, magnitude, zero pad
    output logic [ved_pkg::OUT_TDATA_W-1:0]                        o_m_tdata,
    // log_sample, event_started, event_finished, end_reason, settling
    output logic [ved_pkg::OUT_TUSER_W-1:0]                        o_m_tuser,
    input  logic                                                   i_cfg_valid,
    output logic                                                   o_cfg_ready,
    input  logic [ved_pkg::CFG_IDX_W-1:0]                          i_cfg_index,
    input  logic [ved_pkg::CFG_DATA_W-1:0]                         i_cfg_data
);
    import ved_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int TW = (SB + 1 > 22) ? SB + 1 : 22;
    localparam int DW = (SB > DELTA_W) ? SB : DELTA_W;
    localparam int AW = (SB > LEVEL_W) ? SB : LEVEL_W;

    t_state r_state, n_state;

    logic [LEVEL_W-1:0] r_trig;
    logic [DELTA_W-1:0] r_sdelta;
    logic [TIME_W-1:0]  r_stime;
    logic [TIME_W-1:0]  r_minev;
    logic [TIME_W-1:0]  r_maxev;
    logic [LEVEL_W-1:0] r_reject;

    logic [TIME_W-1:0]  r_time;
    logic               r_motion;
    logic               r_abort;
    logic               r_busy;

    logic               r_acq, n_acq;
    logic [TIME_W-1:0]  r_evt_start, n_evt_start;
    logic [TIME_W-1:0]  r_set_start, n_set_start;
    logic               r_in_settle, n_in_settle;
    logic [SB-1:0]      r_last_mag, n_last_mag;
    logic               r_last_valid, n_last_valid;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user, n_out_user;

    logic              w_accept;
    logic              w_slot;
    logic              w_mag_done;
    logic [SB-1:0]     w_mag;
    logic [SB-1:0]     w_abs [3];
    logic [TIME_W-1:0] w_elapsed;
    logic              w_trig;
    logic [DW-1:0]     w_delta;
    logic              w_quiet;
    logic [TIME_W-1:0] w_sst;
    logic              w_settled;
    logic              w_reject;

    logic              w_log;
    logic [TIME_W-1:0] w_rel;
    logic              w_started;
    logic              w_fin;
    logic [1:0]        w_reason;
    logic              w_settling;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot      = !r_out_valid || i_m_tready;

    ved_mag #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_x     (i_s_tdata[SB-1:0]),
        .i_y     (i_s_tdata[2*SB-1:SB]),
        .i_z     (i_s_tdata[3*SB-1:2*SB]),
        .o_done  (w_mag_done),
        .o_mag   (w_mag),
        .o_abs   (w_abs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig   <= RST_TRIGGER;
            r_sdelta <= RST_SDELTA;
            r_stime  <= RST_STIME;
            r_minev  <= RST_MIN_EVENT;
            r_maxev  <= RST_MAX_EVENT;
            r_reject <= RST_REJECT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRIGGER:   r_trig   <= i_cfg_data[LEVEL_W-1:0];
                CFG_SDELTA:    r_sdelta <= i_cfg_data[DELTA_W-1:0];
                CFG_STIME:     r_stime  <= i_cfg_data[TIME_W-1:0];
                CFG_MIN_EVENT: r_minev  <= i_cfg_data[TIME_W-1:0];
                CFG_MAX_EVENT: r_maxev  <= i_cfg_data[TIME_W-1:0];
                CFG_REJECT:    r_reject <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time   <= i_s_tdata[3*SB +: TIME_W];
            r_motion <= i_s_tuser[U_MOTION];
            r_abort  <= i_s_tuser[U_ABORT];
            r_busy   <= i_s_tuser[U_BUSY];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_acq        <= 1'b0;
            r_evt_start  <= '0;
            r_set_start  <= '0;
            r_in_settle  <= 1'b0;
            r_last_mag   <= '0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_acq        <= n_acq;
            r_evt_start  <= n_evt_start;
            r_set_start  <= n_set_start;
            r_in_settle  <= n_in_settle;
            r_last_mag   <= n_last_mag;
            r_last_valid <= n_last_valid;
            r_out_valid  <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign w_elapsed = r_time - r_evt_start;
    assign w_trig    = r_motion ||
                       ((TW'(w_mag) << 1) > ((TW'(r_trig) << 2) + TW'(r_trig)));
    assign w_delta   = !r_last_valid ? '0 :
                       (w_mag > r_last_mag) ? DW'(w_mag - r_last_mag)
                                            : DW'(r_last_mag - w_mag);
    assign w_quiet   = w_delta < DW'(r_sdelta);
    assign w_sst     = (w_quiet && !r_in_settle) ? r_time : r_set_start;
    assign w_settled = w_quiet && ((r_time - w_sst) > r_stime) && (w_elapsed > r_minev);
    assign w_reject  = (AW'(w_abs[0]) > AW'(r_reject)) ||
                       (AW'(w_abs[1]) > AW'(r_reject)) ||
                       (AW'(w_abs[2]) > AW'(r_reject));

    always_comb begin
        n_state      = r_state;
        n_acq        = r_acq;
        n_evt_start  = r_evt_start;
        n_set_start  = r_set_start;
        n_in_settle  = r_in_settle;
        n_last_mag   = r_last_mag;
        n_last_valid = r_last_valid;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        w_log        = 1'b0;
        w_rel        = '0;
        w_started    = 1'b0;
        w_fin        = 1'b0;
        w_reason     = REASON_SETTLED;
        w_settling   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                if (w_mag_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                    if (!r_acq) begin
                        if (w_trig && !r_abort && !r_busy) begin
                            n_acq        = 1'b1;
                            n_evt_start  = r_time;
                            n_set_start  = '0;
                            n_in_settle  = 1'b0;
                            n_last_valid = 1'b0;
                            n_last_mag   = '0;
                            w_started    = 1'b1;
                        end
                    end else if (w_elapsed >= r_maxev) begin
                        n_acq    = 1'b0;
                        w_fin    = 1'b1;
                        w_reason = REASON_TIMEOUT;
                    end else if (r_abort) begin
                        n_acq    = 1'b0;
                        w_fin    = 1'b1;
                        w_reason = REASON_ABORT;
                    end else begin
                        w_log        = 1'b1;
                        w_rel        = w_elapsed;
                        n_in_settle  = w_quiet;
                        n_set_start  = w_sst;
                        n_last_mag   = w_mag;
                        n_last_valid = 1'b1;
                        w_settling   = w_quiet;
                        if (w_reject) begin
                            n_acq    = 1'b0;
                            w_fin    = 1'b1;
                            w_reason = REASON_REJECT;
                        end else if (w_settled) begin
                            n_acq    = 1'b0;
                            w_fin    = 1'b1;
                            w_reason = REASON_SETTLED;
                        end
                    end
                    n_out_valid                       = 1'b1;
                    n_out_data                        = '0;
                    n_out_data[TIME_W-1:0]            = w_rel;
                    n_out_data[TIME_W +: MAG_OUT_W]   = MAG_OUT_W'(w_mag);
                    n_out_user[U_LOG]                 = w_log;
                    n_out_user[U_START]               = w_started;
                    n_out_user[U_FIN]                 = w_fin;
                    n_out_user[U_REASON +: 2]         = w_reason;
                    n_out_user[U_SETTLE]              = w_settling;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    `VED_ASSERT_IMP(a_rel_zero_unlogged, i_clk, i_rst_n,
                    r_out_valid && !r_out_user[U_LOG], r_out_data[TIME_W-1:0] == '0)
    `VED_ASSERT_IMP(a_reason_needs_fin, i_clk, i_rst_n,
                    r_out_valid && !r_out_user[U_FIN],
                    r_out_user[U_REASON +: 2] == REASON_SETTLED)
    `VED_ASSERT_IMP(a_start_alone, i_clk, i_rst_n,
                    r_out_valid && r_out_user[U_START], !r_out_user[U_LOG] && !r_out_user[U_FIN])
    `VED_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_tready)
    `VED_ASSERT_IMP(a_done_while_waiting, i_clk, i_rst_n, w_mag_done, r_state == S_MAG)

endmodule

// ===== src/ved_mag.sv =====
// Magnitude unit: shared squarer with accumulator, then bit-serial square root.
module ved_mag #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic signed [SAMPLE_BITS-1:0] i_z,
    output logic                          o_done,
    output logic        [SAMPLE_BITS-1:0] o_mag,
    output logic        [SAMPLE_BITS-1:0] o_abs [3]
);
    import ved_pkg::*;

    localparam int PW = 2 * SAMPLE_BITS;
    localparam int RW = SAMPLE_BITS + 2;
    localparam int CW = $clog2(SAMPLE_BITS);

    t_mag_state r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_abs [3];
    logic [SAMPLE_BITS-1:0] n_abs [3];
    logic [1:0]             r_idx, n_idx;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [PW-1:0]          r_acc, n_acc;
    logic [PW-1:0]          r_prod, n_prod;
    logic [PW-1:0]          r_rad, n_rad;
    logic [RW-1:0]          r_rem, n_rem;
    logic [SAMPLE_BITS-1:0] r_root, n_root;
    logic                   r_done, n_done;

    logic [SAMPLE_BITS-1:0] w_op;
    logic [PW-1:0]          w_prod;
    logic [RW-1:0]          w_sh;
    logic [RW-1:0]          w_trial;
    logic                   w_ge;

    function automatic logic [SAMPLE_BITS-1:0] f_abs(input logic signed [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] u;
        u = $unsigned(v);
        f_abs = v[SAMPLE_BITS-1] ? (~u + SAMPLE_BITS'(1)) : u;
    endfunction

    always_comb begin
        unique case (r_idx)
            2'd0:    w_op = r_abs[0];
            2'd1:    w_op = r_abs[1];
            default: w_op = r_abs[2];
        endcase
    end

    assign w_prod  = PW'(w_op) * PW'(w_op);
    assign w_sh    = {r_rem[SAMPLE_BITS-1:0], r_rad[PW-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = (w_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_abs  <= n_abs;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    always_comb begin
        n_state = r_state;
        n_abs   = r_abs;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_done  = 1'b0;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_abs[0] = f_abs(i_x);
                    n_abs[1] = f_abs(i_y);
                    n_abs[2] = f_abs(i_z);
                    n_acc    = '0;
                    n_idx    = '0;
                    n_state  = M_SQ;
                end
            end
            M_SQ: begin
                n_prod = w_prod;
                n_idx  = r_idx + 2'd1;
                if (r_idx != 2'd0) begin
                    n_acc = r_acc + r_prod;
                end
                if (r_idx == 2'd3) begin
                    n_rad   = r_acc + r_prod;
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CW'(SAMPLE_BITS - 1);
                    n_state = M_ROOT;
                end
            end
            M_ROOT: begin
                n_rad  = r_rad << 2;
                n_rem  = w_ge ? (w_sh - w_trial) : w_sh;
                n_root = {r_root[SAMPLE_BITS-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = M_IDLE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_root;
    assign o_abs  = r_abs;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for vibration_event_detector: directed, extreme and random runs.
`timescale 1ns / 1ps

module tb_top;

    import ved_pkg::*;

    localparam int AXIS_W      = 20;
    localparam int IN_TDATA_W  = ((3 * AXIS_W + TIME_W + 7) / 8) * 8;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'hFF;

    typedef struct {
        logic [AXIS_W-1:0] ax;
        logic [AXIS_W-1:0] ay;
        logic [AXIS_W-1:0] az;
        logic [TIME_W-1:0] ms;
        logic              motion;
        logic              abort_req;
        logic              busy;
    } t_sample;

    typedef struct {
        logic                 log_sample;
        logic [TIME_W-1:0]    rel_ms;
        logic                 started;
        logic                 finished;
        logic [1:0]           reason;
        logic [MAG_OUT_W-1:0] mag;
        logic                 settling;
    } t_verdict;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]     i_s_tdata   = '0;
    logic [IN_TUSER_W-1:0]     i_s_tuser   = '0;
    logic                      i_m_tready  = 1'b1;
    logic                      i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data  = '0;
    logic                      o_s_tready;
    logic                      o_m_tvalid;
    logic [OUT_TDATA_W-1:0]    o_m_tdata;
    logic [OUT_TUSER_W-1:0]    o_m_tuser;
    logic                      o_cfg_ready;

    vibration_event_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // detector registers and event state as the predictor sees them
    logic [LEVEL_W-1:0]   trig_level;
    logic [DELTA_W-1:0]   settle_band;
    logic [TIME_W-1:0]    settle_ms;
    logic [TIME_W-1:0]    min_ms;
    logic [TIME_W-1:0]    max_ms;
    logic [LEVEL_W-1:0]   reject_lvl;
    logic                 acq;
    logic                 in_settle_r;
    logic                 prev_valid;
    logic [TIME_W-1:0]    ev_start_ms;
    logic [TIME_W-1:0]    settle_start;
    logic [MAG_OUT_W-1:0] mag_hist;

    t_verdict          pending_verdicts[$];
    int                mismatches = 0;
    int                items_sent = 0;
    int                quiet_cycles = 0;
    int                stall_left = 0;
    logic              gaps_on = 1'b0;
    logic              stalls_on = 1'b0;
    logic [TIME_W-1:0] clock_ms = '0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [AXIS_W-1:0] abs_axis(logic [AXIS_W-1:0] v);
        return v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic t_verdict judge_sample(t_sample s);
        t_verdict             v;
        logic [AXIS_W-1:0]    ax;
        logic [AXIS_W-1:0]    ay;
        logic [AXIS_W-1:0]    az;
        logic [63:0]          root;
        logic [MAG_OUT_W-1:0] mag;
        logic [MAG_OUT_W-1:0] delta;
        logic [TIME_W-1:0]    elapsed;
        logic [TIME_W-1:0]    settled_for;
        logic                 trig;
        ax   = abs_axis(s.ax);
        ay   = abs_axis(s.ay);
        az   = abs_axis(s.az);
        root = int_sqrt(64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az));
        mag  = (root > 64'hFFFFF) ? 20'hFFFFF : root[MAG_OUT_W-1:0];
        v    = '{default: '0};
        v.mag = mag;
        if (!acq) begin
            trig = s.motion || (64'(mag) * 2 > 64'(trig_level) * 5);
            if (trig && !s.abort_req && !s.busy) begin
                acq          = 1'b1;
                ev_start_ms  = s.ms;
                settle_start = '0;
                in_settle_r  = 1'b0;
                prev_valid   = 1'b0;
                mag_hist     = '0;
                v.started    = 1'b1;
            end
        end else begin
            elapsed = s.ms - ev_start_ms;
            if (elapsed >= max_ms) begin
                acq        = 1'b0;
                v.finished = 1'b1;
                v.reason   = REASON_TIMEOUT;
            end else if (s.abort_req) begin
                acq        = 1'b0;
                v.finished = 1'b1;
                v.reason   = REASON_ABORT;
            end else begin
                v.log_sample = 1'b1;
                v.rel_ms     = elapsed;
                delta        = '0;
                if (prev_valid) delta = (mag > mag_hist) ? mag - mag_hist : mag_hist - mag;
                if (delta < settle_band) begin
                    if (!in_settle_r) begin
                        in_settle_r  = 1'b1;
                        settle_start = s.ms;
                    end
                    settled_for = s.ms - settle_start;
                    if (settled_for > settle_ms && elapsed > min_ms) begin
                        acq        = 1'b0;
                        v.finished = 1'b1;
                        v.reason   = REASON_SETTLED;
                    end
                end else begin
                    in_settle_r = 1'b0;
                end
                mag_hist   = mag;
                prev_valid = 1'b1;
                // full-scale rejection overrides a settle on the same item
                if (ax > AXIS_W'(reject_lvl) || ay > AXIS_W'(reject_lvl) ||
                    az > AXIS_W'(reject_lvl)) begin
                    acq        = 1'b0;
                    v.finished = 1'b1;
                    v.reason   = REASON_REJECT;
                end
                v.settling = in_settle_r;
            end
        end
        return v;
    endfunction

    function automatic t_sample make_sample(int x, int y, int z, logic [TIME_W-1:0] ms,
                                            logic motion, logic abort_req, logic busy);
        t_sample s;
        int      axes[3];
        axes = '{x, y, z};
        foreach (axes[k]) begin
            if (axes[k] > 524287) axes[k] = 524287;
            if (axes[k] < -524288) axes[k] = -524288;
        end
        s.ax        = axes[0][AXIS_W-1:0];
        s.ay        = axes[1][AXIS_W-1:0];
        s.az        = axes[2][AXIS_W-1:0];
        s.ms        = ms;
        s.motion    = motion;
        s.abort_req = abort_req;
        s.busy      = busy;
        return s;
    endfunction

    function automatic t_sample noise_sample();
        t_sample s;
        s.ax        = AXIS_W'($urandom());
        s.ay        = AXIS_W'($urandom());
        s.az        = AXIS_W'($urandom());
        s.ms        = $urandom();
        s.motion    = 1'($urandom_range(0, 1));
        s.abort_req = 1'($urandom_range(0, 1));
        s.busy      = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic int rand_axis(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_idle();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TRIGGER:   trig_level  = val[LEVEL_W-1:0];
            CFG_SDELTA:    settle_band = val[DELTA_W-1:0];
            CFG_STIME:     settle_ms   = val;
            CFG_MIN_EVENT: min_ms      = val;
            CFG_MAX_EVENT: max_ms      = val;
            CFG_REJECT:    reject_lvl  = val[LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_sample(t_sample s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata = {4'd0, s.ms, s.az, s.ay, s.ax};
        i_s_tuser[U_MOTION] = s.motion;
        i_s_tuser[U_ABORT]  = s.abort_req;
        i_s_tuser[U_BUSY]   = s.busy;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_verdicts.push_back(judge_sample(s));
        items_sent++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    // trigger item, then a run of samples jittering around one vector
    task automatic run_event(int n_after);
        t_sample s;
        int      lim;
        int      jit;
        int      bx;
        int      by;
        int      bz;
        int      r;
        case ($urandom_range(0, 3))
            0: lim = 3000;
            1: lim = 60000;
            2: lim = 300000;
            default: lim = 524288;
        endcase
        case ($urandom_range(0, 3))
            0: jit = 0;
            1: jit = 40;
            2: jit = 1500;
            default: jit = 40000;
        endcase
        bx = rand_axis(lim);
        by = rand_axis(lim);
        bz = rand_axis(lim);
        clock_ms += $urandom_range(1, 40);
        s = make_sample(bx, by, bz, clock_ms, $urandom_range(0, 3) != 0,
                        $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
        send_sample(s);
        for (int j = 0; j < n_after; j++) begin
            r = $urandom_range(0, 99);
            if (r < 3) clock_ms += $urandom();
            else if (r < 8) clock_ms += $urandom_range(300, 3000);
            else clock_ms += $urandom_range(1, 20);
            s = make_sample(bx + rand_axis(jit), by + rand_axis(jit), bz + rand_axis(jit),
                            clock_ms, 1'($urandom_range(0, 1)), $urandom_range(0, 29) == 0,
                            1'($urandom_range(0, 1)));
            if ($urandom_range(0, 39) == 0) s.ay = $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
            send_sample(s);
        end
    endtask

    task automatic exercise();
        run_event(4);
        run_event(4);
        send_sample(noise_sample());
    endtask

    task automatic test_directed_defaults();
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] t2;
        t  = 32'h0000_1000;
        t2 = 32'h0100_0000;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_sample(make_sample(0, 0, 0, t, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(0, 0, 0, t + 1, 1'b1, 1'b0, 1'b1));
        send_sample(make_sample(0, 0, 0, t + 2, 1'b1, 1'b1, 1'b0));
        // magnitude exactly at 2.5x trigger does not start
        send_sample(make_sample(32000, 0, 0, t + 3, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(0, -32001, 0, t + 4, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(0, -32001, 0, t + 14, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(0, -32001, 100, t + 24, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(0, 0, 0, t + 34, 1'b0, 1'b1, 1'b0));
        // timeout takes priority over abort
        send_sample(make_sample(0, 0, 0, t + 100, 1'b1, 1'b0, 1'b0));
        send_sample(make_sample(0, 0, 0, t + 100 + 900000, 1'b0, 1'b1, 1'b0));
        send_sample(make_sample(524287, 524287, 524287, t + 1000000, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(-524288, 0, 0, t + 1000010, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(-524288, -524288, -524288, t + 1000020, 1'b1, 1'b0, 1'b1));
        // event across the timestamp wrap, then settles
        send_sample(make_sample(0, 0, 0, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b0));
        send_sample(make_sample(5000, 5000, 5000, 32'h0000_0010, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(5000, 5000, 5001, 32'h0000_0010 + 3001, 1'b0, 1'b0, 1'b0));
        // rejection on a settling item
        send_sample(make_sample(0, 0, 0, t2, 1'b1, 1'b0, 1'b0));
        send_sample(make_sample(490000, 0, 0, t2 + 10, 1'b0, 1'b0, 1'b0));
        // settling broken by a large change, restarted, then aborted
        send_sample(make_sample(0, 0, 0, t2 + 20, 1'b1, 1'b0, 1'b0));
        send_sample(make_sample(100000, 0, 0, t2 + 30, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(103000, 0, 0, t2 + 3031, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(103000, 0, 0, t2 + 3041, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(103000, 0, 0, t2 + 3051, 1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_register_extremes();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        clock_ms  = $urandom();
        write_reg(CFG_STIME, 32'd20);
        write_reg(CFG_MIN_EVENT, 32'd40);
        write_reg(CFG_MAX_EVENT, 32'd300);
        write_reg(CFG_TRIGGER, 32'd0);
        exercise();
        write_reg(CFG_TRIGGER, 32'hFFFF_FFFF);
        exercise();
        write_reg(CFG_TRIGGER, 32'd5000);
        write_reg(CFG_SDELTA, 32'd0);
        exercise();
        write_reg(CFG_SDELTA, 32'hFFFF_FFFF);
        exercise();
        write_reg(CFG_SDELTA, 32'd1000);
        write_reg(CFG_STIME, 32'd0);
        exercise();
        write_reg(CFG_STIME, 32'hFFFF_FFFF);
        exercise();
        write_reg(CFG_STIME, 32'd20);
        write_reg(CFG_MIN_EVENT, 32'd0);
        exercise();
        write_reg(CFG_MIN_EVENT, 32'hFFFF_FFFF);
        exercise();
        write_reg(CFG_MIN_EVENT, 32'd40);
        write_reg(CFG_MAX_EVENT, 32'd0);
        exercise();
        write_reg(CFG_MAX_EVENT, 32'd1);
        exercise();
        write_reg(CFG_MAX_EVENT, 32'hFFFF_FFFF);
        exercise();
        write_reg(CFG_MAX_EVENT, 32'd300);
        write_reg(CFG_REJECT, 32'd0);
        exercise();
        write_reg(CFG_REJECT, 32'hFFFF_FFFF);
        exercise();
        write_reg(CFG_REJECT, 32'd480000);
        // writes to unmapped indexes change nothing
        write_reg(CFG_UNUSED_LOW, 32'd0);
        write_reg(CFG_UNUSED_TOP, 32'd0);
        exercise();
    endtask

    task automatic test_random_events();
        int first;
        int r;
        clock_ms = $urandom();
        for (int phase = 0; phase < 8; phase++) begin
            gaps_on   = (phase != 0) && ($urandom_range(0, 3) != 0);
            stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            write_reg(CFG_TRIGGER, $urandom_range(0, 30000));
            write_reg(CFG_SDELTA, $urandom_range(0, 3000));
            write_reg(CFG_STIME, $urandom_range(0, 60));
            write_reg(CFG_MIN_EVENT, $urandom_range(0, 100));
            r = $urandom_range(0, 7);
            write_reg(CFG_MAX_EVENT, (r == 0) ? 32'hFFFF_FFFF :
                                     (r == 1) ? $urandom_range(0, 2) : $urandom_range(80, 400));
            write_reg(CFG_REJECT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 524287)
                                                              : $urandom_range(420000, 524287));
            first = items_sent;
            while (items_sent - first < 38) begin
                if ($urandom_range(0, 9) == 0) send_sample(noise_sample());
                else run_event($urandom_range(1, 14));
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result item with no expectation pending");
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("log_sample", 32'(want.log_sample), 32'(o_m_tuser[U_LOG]));
                check_field("rel_time_ms", want.rel_ms, o_m_tdata[0 +: TIME_W]);
                check_field("event_started", 32'(want.started), 32'(o_m_tuser[U_START]));
                check_field("event_finished", 32'(want.finished), 32'(o_m_tuser[U_FIN]));
                check_field("end_reason", 32'(want.reason), 32'(o_m_tuser[U_REASON +: 2]));
                check_field("magnitude", 32'(want.mag), 32'(o_m_tdata[TIME_W +: MAG_OUT_W]));
                check_field("settling", 32'(want.settling), 32'(o_m_tuser[U_SETTLE]));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!stalls_on) begin
            i_m_tready = 1'b1;
        end else if (stall_left > 0) begin
            i_m_tready = 1'b0;
            stall_left--;
        end else begin
            i_m_tready = 1'b1;
            if ($urandom_range(0, 99) < 20) stall_left = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 4) stall_left = $urandom_range(10, 60);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        trig_level   = RST_TRIGGER;
        settle_band  = RST_SDELTA;
        settle_ms    = RST_STIME;
        min_ms       = RST_MIN_EVENT;
        max_ms       = RST_MAX_EVENT;
        reject_lvl   = RST_REJECT;
        acq          = 1'b0;
        in_settle_r  = 1'b0;
        prev_valid   = 1'b0;
        ev_start_ms  = '0;
        settle_start = '0;
        mag_hist     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_defaults();
        test_register_extremes();
        test_random_events();
        wait_idle();
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
